// ===== rtl/modular_exponentiation_unit_macros.svh =====
// assertion macros used by the checker file mexp_checker.sv
`ifndef MODULAR_EXPONENTIATION_UNIT_MACROS_SVH
`define MODULAR_EXPONENTIATION_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define MEXP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("modexp check failed");

// next-cycle implication, checked outside reset
`define MEXP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("modexp check failed");

`endif

// ===== rtl/mexp_pkg.sv =====
`timescale 1ns / 1ps
package mexp_pkg;
   localparam int OPERAND_WORDS = 16;
   localparam int WORD_BITS     = 64;
   localparam int IDX_BITS      = 4;
   localparam int TOTAL_BITS    = OPERAND_WORDS * WORD_BITS;
   localparam int BIT_BITS      = $clog2(TOTAL_BITS);
   localparam int SEL_BITS      = $clog2(WORD_BITS);
   localparam int REQ_DATA_BITS = 72;
   localparam int RSP_DATA_BITS = 72;
   localparam logic [IDX_BITS-1:0] WORD_LAST = IDX_BITS'(OPERAND_WORDS - 1);

   typedef enum logic [1:0] {
      CMD_BASE  = 2'd0,
      CMD_EXP   = 2'd1,
      CMD_MOD   = 2'd2,
      CMD_START = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CLR,
      ST_RED,
      ST_CPY,
      ST_EXP,
      ST_EXPB,
      ST_CPR,
      ST_CPX,
      ST_MA,
      ST_MB,
      ST_NXT,
      ST_OUT
   } state_type;
endpackage

// ===== rtl/modular_exponentiation_unit.sv =====
// Modular exponentiation unit. Load requests (base, exponent or modulus word, one 64-bit word
// each) are taken while idle. A start request computes base^exponent mod modulus over
// 1024-bit operands and returns 16 result words, low word first, the last one marked with
// tlast; tuser flags a zero modulus (result words then zero). A zero exponent returns 1.
// All wide arithmetic runs through one 64-bit add/subtract unit that walks the 16 words of
// an operand, one word per cycle. A start scans the operands, reduces the base, and then for
// every exponent bit after the first one does a squaring plus, for a set bit, one more
// multiplication; each multiplication walks the multiplier bits with a doubling pass per bit
// and an addition pass per set bit. The unit takes no request while a start is in progress.
`timescale 1ns / 1ps
module modular_exponentiation_unit import mexp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,   // word_index[3:0], load_data[67:4], zero pad
   input  logic [1:0]               req_tuser,   // command[1:0]
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,   // result_word[63:0], result_index[67:64], pad
   output logic                     rsp_tlast,   // last_word
   output logic                     rsp_tuser    // modulus_error
);
   state_type state_ff, state_in;

   logic [WORD_BITS-1:0] base_ff [OPERAND_WORDS];
   logic [WORD_BITS-1:0] exp_ff  [OPERAND_WORDS];
   logic [WORD_BITS-1:0] mod_ff  [OPERAND_WORDS];
   logic [WORD_BITS-1:0] acc_ff  [2][OPERAND_WORDS];
   logic [WORD_BITS-1:0] x_ff    [OPERAND_WORDS];
   logic [WORD_BITS-1:0] y_ff    [OPERAND_WORDS];

   logic                cur_ff;
   logic [IDX_BITS-1:0] w_ff;
   logic [BIT_BITS-1:0] bit_ff;
   logic [BIT_BITS-1:0] ebit_ff;
   logic                carry_ff, borrow_ff;
   logic                sq_ff, started_ff;
   logic                mnz_ff, enz_ff, err_ff, ezero_ff;

   cmd_type             cmd;
   logic [IDX_BITS-1:0] req_idx;
   logic [WORD_BITS-1:0] req_word;
   logic                req_fire, rsp_fire, last_w;
   logic [WORD_BITS-1:0] rw, addw, tw, dw;
   logic                cin, bin, tc, bo, ge, phase_b;
   logic [WORD_BITS:0]  sum65, diff65;
   logic                base_bit, x_bit, e_bit;
   logic                mnz_now, enz_now;

   // request fields
   assign cmd      = cmd_type'(req_tuser);
   assign req_idx  = req_tdata[IDX_BITS-1:0];
   assign req_word = req_tdata[IDX_BITS +: WORD_BITS];
   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign last_w   = (w_ff == WORD_LAST);

   // bit taps of the operands
   assign base_bit = base_ff[bit_ff[BIT_BITS-1:SEL_BITS]][bit_ff[SEL_BITS-1:0]];
   assign x_bit    = x_ff[bit_ff[BIT_BITS-1:SEL_BITS]][bit_ff[SEL_BITS-1:0]];
   assign e_bit    = exp_ff[ebit_ff[BIT_BITS-1:SEL_BITS]][ebit_ff[SEL_BITS-1:0]];

   // shared word unit: shift or add, then trial subtract of the modulus
   always_comb begin
      rw      = acc_ff[cur_ff][w_ff];
      phase_b = (state_ff == ST_MB);
      addw    = sq_ff ? x_ff[w_ff] : y_ff[w_ff];
      if (w_ff == '0) begin
         cin = (state_ff == ST_RED) ? base_bit : 1'b0;
         bin = 1'b0;
      end else begin
         cin = carry_ff;
         bin = borrow_ff;
      end
      sum65 = {1'b0, rw} + {1'b0, addw} + {{WORD_BITS{1'b0}}, cin};
      if (phase_b) begin
         tw = sum65[WORD_BITS-1:0];
         tc = sum65[WORD_BITS];
      end else begin
         tw = {rw[WORD_BITS-2:0], cin};
         tc = rw[WORD_BITS-1];
      end
      diff65 = {1'b0, tw} - {1'b0, mod_ff[w_ff]} - {{WORD_BITS{1'b0}}, bin};
      dw = diff65[WORD_BITS-1:0];
      bo = diff65[WORD_BITS];
      ge = tc || !bo;
   end

   // operand scan flags
   assign mnz_now = mnz_ff || (|mod_ff[w_ff]);
   assign enz_now = enz_ff || (|exp_ff[w_ff]);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_fire && cmd == CMD_START) state_in = ST_SCAN;
         ST_SCAN: begin
            if (last_w) state_in = (mnz_now && enz_now) ? ST_CLR : ST_OUT;
         end
         ST_CLR: if (last_w) state_in = ST_RED;
         ST_RED: if (last_w && bit_ff == '0) state_in = ST_CPY;
         ST_CPY: if (last_w) state_in = ST_EXP;
         ST_EXP: begin
            if (started_ff) state_in = ST_CPX;
            else if (e_bit) state_in = ST_CPR;
            else state_in = ST_NXT;
         end
         ST_EXPB: state_in = e_bit ? ST_CPX : ST_NXT;
         ST_CPR: if (last_w) state_in = ST_NXT;
         ST_CPX: if (last_w) state_in = ST_MA;
         ST_MA: begin
            if (last_w) begin
               if (x_bit) state_in = ST_MB;
               else if (bit_ff == '0) state_in = sq_ff ? ST_EXPB : ST_NXT;
            end
         end
         ST_MB: begin
            if (last_w) begin
               if (bit_ff == '0) state_in = sq_ff ? ST_EXPB : ST_NXT;
               else state_in = ST_MA;
            end
         end
         ST_NXT: state_in = (ebit_ff == '0) ? ST_OUT : ST_EXP;
         ST_OUT: if (rsp_fire && last_w) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // handshake and result outputs
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_OUT);
      rsp_tlast  = last_w;
      rsp_tuser  = err_ff;
      rsp_tdata  = '0;
      if (err_ff) rsp_tdata[WORD_BITS-1:0] = '0;
      else if (ezero_ff) rsp_tdata[WORD_BITS-1:0] = (w_ff == '0) ? WORD_BITS'(1) : '0;
      else rsp_tdata[WORD_BITS-1:0] = rw;
      rsp_tdata[WORD_BITS +: IDX_BITS] = w_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cur_ff     <= 1'b0;
         w_ff       <= '0;
         bit_ff     <= '0;
         ebit_ff    <= '0;
         sq_ff      <= 1'b0;
         started_ff <= 1'b0;
         mnz_ff     <= 1'b0;
         enz_ff     <= 1'b0;
         err_ff     <= 1'b0;
         ezero_ff   <= 1'b0;
         for (int i = 0; i < OPERAND_WORDS; i++) begin
            base_ff[i] <= '0;
            exp_ff[i]  <= '0;
            mod_ff[i]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  case (cmd)
                     CMD_BASE: base_ff[req_idx] <= req_word;
                     CMD_EXP:  exp_ff[req_idx]  <= req_word;
                     CMD_MOD:  mod_ff[req_idx]  <= req_word;
                     default: begin
                        w_ff       <= '0;
                        mnz_ff     <= 1'b0;
                        enz_ff     <= 1'b0;
                        started_ff <= 1'b0;
                        sq_ff      <= 1'b0;
                        ebit_ff    <= '1;
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               mnz_ff <= mnz_now;
               enz_ff <= enz_now;
               w_ff   <= w_ff + 1'b1;
               if (last_w) begin
                  err_ff   <= !mnz_now;
                  ezero_ff <= mnz_now && !enz_now;
               end
            end
            ST_CLR, ST_CPY, ST_CPR: begin
               w_ff <= w_ff + 1'b1;
               if (last_w) bit_ff <= '1;
            end
            ST_CPX: begin
               w_ff <= w_ff + 1'b1;
               if (last_w) bit_ff <= '1;
            end
            ST_RED, ST_MA, ST_MB: begin
               w_ff <= w_ff + 1'b1;
               if (last_w) begin
                  if (ge) cur_ff <= !cur_ff;
                  if (!(state_ff == ST_MA && x_bit)) bit_ff <= bit_ff - 1'b1;
               end
            end
            ST_EXP: begin
               if (started_ff) sq_ff <= 1'b1;
               else if (e_bit) started_ff <= 1'b1;
            end
            ST_EXPB: sq_ff <= 1'b0;
            ST_NXT: ebit_ff <= ebit_ff - 1'b1;
            ST_OUT: if (rsp_fire) w_ff <= w_ff + 1'b1;
            default: ;
         endcase
      end
   end

   // word datapath storage
   always_ff @(posedge clock) begin
      carry_ff  <= tc;
      borrow_ff <= bo;
      case (state_ff)
         ST_CLR: acc_ff[cur_ff][w_ff] <= '0;
         ST_CPY: y_ff[w_ff] <= rw;
         ST_CPR: acc_ff[cur_ff][w_ff] <= y_ff[w_ff];
         ST_CPX: begin
            x_ff[w_ff]           <= rw;
            acc_ff[cur_ff][w_ff] <= '0;
         end
         ST_RED, ST_MA, ST_MB: begin
            acc_ff[cur_ff][w_ff]  <= tw;
            acc_ff[!cur_ff][w_ff] <= dw;
         end
         default: ;
      endcase
   end
endmodule

// ===== rtl/mexp_checker.sv =====
`timescale 1ns / 1ps
`include "modular_exponentiation_unit_macros.svh"
module mexp_checker import mexp_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic [REQ_DATA_BITS-1:0] req_tdata,
   input logic [1:0]               req_tuser,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                     rsp_tlast,
   input logic                     rsp_tuser
);
   // no request taken while results are out
   `MEXP_ASSERT_NOW(a_busy_out, rsp_tvalid, !req_tready)
   // last marker sits on the top word
   `MEXP_ASSERT_NOW(a_last_idx, rsp_tvalid, rsp_tlast == (rsp_tdata[67:64] == WORD_LAST))
   // error results carry zero words
   `MEXP_ASSERT_NOW(a_err_zero, rsp_tvalid && rsp_tuser, rsp_tdata[63:0] == '0)
   // a run ends after its last word
   `MEXP_ASSERT_NEXT(a_run_end, rsp_tvalid && rsp_tready && rsp_tlast, !rsp_tvalid)
endmodule

bind modular_exponentiation_unit mexp_checker u_mexp_checker (.*);
